// ===== design/colour_state_stack_top_defines.svh =====
// Assertion macros for the colour state stack.
`ifndef COLOUR_STATE_STACK_TOP_DEFINES_SVH
`define COLOUR_STATE_STACK_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define CSSTK_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("csstk: invariant violated");

`define CSSTK_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csstk: implication violated");

`define CSSTK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csstk: next-cycle check violated");

`else

`define CSSTK_ASSERT_ALWAYS(label, clk, rst, expr)
`define CSSTK_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSSTK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/csstk_pkg.sv =====
`timescale 1ns / 1ps

package csstk_pkg;

   localparam int STACK_DEPTH  = 64;
   localparam int CHANNEL_BITS = 8;

   localparam int CHAN_W  = CHANNEL_BITS;
   localparam int PROD_W  = 2 * CHAN_W;
   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CMD_W   = 2;

   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [LEVEL_W-1:0] level_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } colour_type;

   localparam chan_type CHAN_MAX = '1;

   localparam cmd_type CMD_PUSH = 2'd0;
   localparam cmd_type CMD_POP  = 2'd1;
   localparam cmd_type CMD_MUL  = 2'd2;

endpackage

// ===== design/colour_state_stack_top.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake             | word
// req     | in        | req_valid / req_stall | cmd, four multiply factors
// rsp     | out       | rsp_valid / rsp_stall | current colour, depth, error flag
//
// Each item is accepted, then finished. The stack read (pop) and the
// channel products (multiply) are registered in the accept cycle.
// A new item is taken while a result waits; it finishes once rsp frees up.
// Reset: current colour opaque white, stack empty. Stack RAM is not cleared.
// req_stall is high from accept until the item finishes, including while it
// waits for rsp to free up.

module colour_state_stack_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  csstk_pkg::cmd_type          req_cmd,
   input  csstk_pkg::chan_type         req_mul_red,
   input  csstk_pkg::chan_type         req_mul_green,
   input  csstk_pkg::chan_type         req_mul_blue,
   input  csstk_pkg::chan_type         req_mul_alpha,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output csstk_pkg::chan_type         rsp_out_red,
   output csstk_pkg::chan_type         rsp_out_green,
   output csstk_pkg::chan_type         rsp_out_blue,
   output csstk_pkg::chan_type         rsp_out_alpha,
   output csstk_pkg::level_type        rsp_depth_used,
   output logic                        rsp_stack_error
);
   import csstk_pkg::*;

`include "colour_state_stack_top_defines.svh"

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   localparam colour_type WHITE = '{red: CHAN_MAX, green: CHAN_MAX,
                                    blue: CHAN_MAX, alpha: CHAN_MAX};
   localparam level_type  FULL  = LEVEL_W'(STACK_DEPTH);

   state_type  state_ff, state_in;
   level_type  level_ff, level_in;
   colour_type colour_ff, colour_in;
   cmd_type    cmd_ff;
   colour_type rd_data_ff;
   colour_type mem [STACK_DEPTH];

   logic       rsp_valid_ff, rsp_valid_in;
   colour_type rsp_colour_ff;
   level_type  rsp_level_ff;
   logic       rsp_error_ff;

   logic       req_accept;
   logic       out_free;
   logic       finish;
   logic       err;
   logic       level_edge;
   level_type  level_dec;
   colour_type factor;
   colour_type mod_result;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == S_EXEC) && out_free;
   assign level_dec  = level_ff - LEVEL_W'(1);
   assign level_edge = (level_ff == '0) || (level_ff == FULL);

   assign factor = '{red: req_mul_red, green: req_mul_green,
                     blue: req_mul_blue, alpha: req_mul_alpha};

   csstk_modulate u_modulate (
      .clock  (clock),
      .load   (req_accept),
      .colour (colour_ff),
      .factor (factor),
      .result (mod_result)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (req_cmd == CMD_PUSH && level_ff < FULL) begin
            mem[level_ff[ADDR_W-1:0]] <= colour_ff;
         end
         rd_data_ff <= mem[level_dec[ADDR_W-1:0]];
         cmd_ff     <= req_cmd;
      end
   end

   always_comb begin
      colour_in = colour_ff;
      level_in  = level_ff;
      err       = 1'b0;
      case (cmd_ff)
         CMD_PUSH: begin
            if (level_ff < FULL) begin
               level_in = level_ff + LEVEL_W'(1);
            end else begin
               err = 1'b1;
            end
         end
         CMD_POP: begin
            if (level_ff != '0) begin
               level_in  = level_dec;
               colour_in = rd_data_ff;
            end else begin
               err = 1'b1;
            end
         end
         CMD_MUL: begin
            colour_in = mod_result;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         colour_ff    <= WHITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            level_ff  <= level_in;
            colour_ff <= colour_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_colour_ff <= colour_in;
         rsp_level_ff  <= level_in;
         rsp_error_ff  <= err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = rsp_colour_ff.red;
   assign rsp_out_green   = rsp_colour_ff.green;
   assign rsp_out_blue    = rsp_colour_ff.blue;
   assign rsp_out_alpha   = rsp_colour_ff.alpha;
   assign rsp_depth_used  = rsp_level_ff;
   assign rsp_stack_error = rsp_error_ff;

   `CSSTK_ASSERT_ALWAYS(a_level_range, clock, reset, level_ff <= FULL)
   `CSSTK_ASSERT_IMPL(a_accept_idle, clock, reset, req_accept, state_ff == S_IDLE)
   `CSSTK_ASSERT_NEXT(a_finish_rsp, clock, reset, finish, rsp_valid_ff && state_ff == S_IDLE)
   `CSSTK_ASSERT_IMPL(a_error_edge, clock, reset, rsp_valid_ff && rsp_error_ff, level_edge)

endmodule

// ===== design/csstk_modulate.sv =====
`timescale 1ns / 1ps

module csstk_modulate (
   input  logic                  clock,
   input  logic                  load,
   input  csstk_pkg::colour_type colour,
   input  csstk_pkg::colour_type factor,
   output csstk_pkg::colour_type result
);
   import csstk_pkg::*;

   typedef logic [PROD_W-1:0] prod_type;

   // round(p / M) with M = 2^CHAN_W - 1, exact for p <= M*M
   function automatic chan_type round_div(prod_type p);
      logic [PROD_W:0] x;
      logic [PROD_W:0] s;
      x = {1'b0, p} + (PROD_W + 1)'(CHAN_MAX >> 1);
      s = x + (x >> CHAN_W) + (PROD_W + 1)'(1);
      return s[CHAN_W +: CHAN_W];
   endfunction

   chan_type col_ch [4];
   chan_type fac_ch [4];
   prod_type prod_ff [4];

   always_comb begin
      col_ch[0] = colour.red;
      col_ch[1] = colour.green;
      col_ch[2] = colour.blue;
      col_ch[3] = colour.alpha;
      fac_ch[0] = factor.red;
      fac_ch[1] = factor.green;
      fac_ch[2] = factor.blue;
      fac_ch[3] = factor.alpha;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= PROD_W'(col_ch[i]) * PROD_W'(fac_ch[i]);
         end
      end
   end

   always_comb begin
      result.red   = round_div(prod_ff[0]);
      result.green = round_div(prod_ff[1]);
      result.blue  = round_div(prod_ff[2]);
      result.alpha = round_div(prod_ff[3]);
   end

endmodule
